// ===== sv/wjr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjr_pkg
// Shared types and sizes for the write journal ring: request and response
// structs, the operation codes and the stored record layout.
// ----------------------------------------------------------------------------
package wjr_pkg;

  localparam int RING_RECORDS = 1024;
  localparam int IDX_W        = $clog2(RING_RECORDS);
  localparam int CNT_W        = $clog2(RING_RECORDS + 1);
  localparam int LIVE_W       = 11;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_DROP   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [39:0]  event_time;
    logic [15:0]  write_addr;
    logic         is_io;
    logic [15:0]  fetch_pc;
    logic [7:0]   data_value;
    logic [7:0]   phys_page;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [39:0]       found_time;
    logic [15:0]       found_addr;
    logic [15:0]       found_pc;
    logic [7:0]        found_value;
    logic [7:0]        found_page;
    logic [LIVE_W-1:0] live_count;
    logic [39:0]       oldest_time;
    logic [39:0]       newest_time;
  } rsp_t;

  typedef struct packed {
    logic [39:0] rec_time;
    logic [15:0] addr;
    logic        io;
    logic [15:0] pc;
    logic [7:0]  value;
    logic [7:0]  page;
  } rec_t;

endpackage

// ===== sv/write_journal_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// write_journal_ring
// Ring journal of memory-write records with append, reverse search for the
// last matching write, drop of records newer than a time, and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_req_i under in_valid_i / in_stall_o; each request
//   gives exactly one response on out_rsp_o under out_valid_o / out_stall_i.
//   The block works on one request at a time and holds in_stall_o high from
//   acceptance until the response is loaded into the output register, so the
//   next request can be taken only once the response is loaded.
//   A request that leaves records in the ring ends with a status phase
//   (S_STATS, S_OLD, S_OLD2, S_NEW) that reads the oldest and the newest live
//   record from the record memory; one that leaves the ring empty ends with
//   S_STATS alone. Find walks the records from the newest back to the match
//   (all live records on a miss), and drop checks the records from the newest
//   back; append and clear examine none. Each examined record costs one
//   memory read and one check on the shared comparator.
//   Reset clears the head index, the live count and all handshake state;
//   record memory contents are not cleared and are never read before being
//   written. While out_stall_i holds a response, the next request may still
//   be accepted and processed; it waits in its final state until the
//   output register frees up.
// ----------------------------------------------------------------------------
module write_journal_ring (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wjr_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wjr_pkg::rsp_t out_rsp_o
);
  import wjr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_DROP_RD,
    S_DROP_CHK,
    S_STATS,
    S_OLD,
    S_OLD2,
    S_NEW,
    S_DONE
  } state_e;

  state_e           state_q;
  req_t             req_q;
  logic [IDX_W-1:0] head_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] ptr_q;
  logic [CNT_W-1:0] left_q;
  logic             found_q;
  rec_t             hit_q;
  logic [39:0]      oldest_q;
  logic [39:0]      newest_q;
  logic             out_valid_q;
  rsp_t             out_rsp_q;

  rec_t             mem [RING_RECORDS];
  rec_t             rd_q;
  logic             mem_we;
  rec_t             wr_rec;

  logic             accept;
  logic             out_free;
  logic [IDX_W-1:0] newest_slot;
  logic [IDX_W-1:0] ptr_prev;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W:0]   old_sum;
  logic [IDX_W-1:0] oldest_slot;
  logic             time_later;
  logic             addr_match;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign mem_we          = accept && (in_req_i.kind == KIND_APPEND);
  assign wr_rec.rec_time = in_req_i.event_time;
  assign wr_rec.addr     = in_req_i.write_addr;
  assign wr_rec.io       = in_req_i.is_io;
  assign wr_rec.pc       = in_req_i.fetch_pc;
  assign wr_rec.value    = in_req_i.data_value;
  assign wr_rec.page     = in_req_i.phys_page;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[head_q] <= wr_rec;
    end
    rd_q <= mem[ptr_q];
  end

  // Ring arithmetic without assuming a power-of-two depth.
  assign newest_slot = (head_q == '0) ? IDX_W'(RING_RECORDS - 1) : head_q - 1'b1;
  assign ptr_prev    = (ptr_q == '0) ? IDX_W'(RING_RECORDS - 1) : ptr_q - 1'b1;
  assign head_next   = (head_q == IDX_W'(RING_RECORDS - 1)) ? '0 : head_q + 1'b1;
  assign old_sum     = {1'b0, head_q} + (IDX_W + 1)'(RING_RECORDS)
                       - (IDX_W + 1)'(count_q);
  assign oldest_slot = (old_sum >= (IDX_W + 1)'(RING_RECORDS))
                       ? IDX_W'(old_sum - (IDX_W + 1)'(RING_RECORDS))
                       : old_sum[IDX_W-1:0];

  // Shared comparator on the record just read.
  assign time_later = (rd_q.rec_time > req_q.event_time);
  assign addr_match = (rd_q.addr == req_q.write_addr) && (rd_q.io == req_q.is_io);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      left_q      <= '0;
      hit_q       <= '0;
      oldest_q    <= '0;
      newest_q    <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
      found_q     <= 1'b0;
    end else begin
      // In the final state the output register is reloaded below instead.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q   <= in_req_i;
            found_q <= 1'b0;
            hit_q   <= '0;
            ptr_q   <= newest_slot;
            left_q  <= count_q;
            unique case (in_req_i.kind)
              KIND_APPEND: begin
                head_q <= head_next;
                if (count_q != CNT_W'(RING_RECORDS)) begin
                  count_q <= count_q + 1'b1;
                end
                state_q <= S_STATS;
              end
              KIND_FIND: begin
                state_q <= (count_q == '0) ? S_STATS : S_FIND_RD;
              end
              KIND_DROP: begin
                state_q <= (count_q == '0) ? S_STATS : S_DROP_RD;
              end
              KIND_CLEAR: begin
                head_q  <= '0;
                count_q <= '0;
                state_q <= S_STATS;
              end
              default: state_q <= S_STATS;
            endcase
          end
        end
        S_FIND_RD: begin
          state_q <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (!time_later && addr_match) begin
            found_q <= 1'b1;
            hit_q   <= rd_q;
            state_q <= S_STATS;
          end else if (left_q == CNT_W'(1)) begin
            state_q <= S_STATS;
          end else begin
            left_q  <= left_q - 1'b1;
            ptr_q   <= ptr_prev;
            state_q <= S_FIND_RD;
          end
        end
        S_DROP_RD: begin
          state_q <= S_DROP_CHK;
        end
        S_DROP_CHK: begin
          if (time_later) begin
            head_q  <= ptr_q;
            count_q <= count_q - 1'b1;
            ptr_q   <= ptr_prev;
            state_q <= (count_q == CNT_W'(1)) ? S_STATS : S_DROP_RD;
          end else begin
            state_q <= S_STATS;
          end
        end
        S_STATS: begin
          if (count_q == '0) begin
            oldest_q <= '0;
            newest_q <= '0;
            state_q  <= S_DONE;
          end else begin
            ptr_q   <= oldest_slot;
            state_q <= S_OLD;
          end
        end
        S_OLD: begin
          // The oldest slot is being read; line up the newest behind it.
          ptr_q   <= newest_slot;
          state_q <= S_OLD2;
        end
        S_OLD2: begin
          oldest_q <= rd_q.rec_time;
          state_q  <= S_NEW;
        end
        S_NEW: begin
          newest_q <= rd_q.rec_time;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q            <= 1'b1;
            out_rsp_q.found        <= found_q;
            out_rsp_q.found_time   <= hit_q.rec_time;
            out_rsp_q.found_addr   <= hit_q.addr;
            out_rsp_q.found_pc     <= hit_q.pc;
            out_rsp_q.found_value  <= hit_q.value;
            out_rsp_q.found_page   <= hit_q.page;
            out_rsp_q.live_count   <= LIVE_W'(count_q);
            out_rsp_q.oldest_time  <= oldest_q;
            out_rsp_q.newest_time  <= newest_q;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
